[design/vsuc_pkg.sv]
package vsuc_pkg;

  localparam int unsigned NUM_W = 32;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2e;
  localparam logic [7:0] CHAR_DASH = 8'h2d;
  localparam logic [7:0] CHAR_R    = 8'h72;
  localparam logic [7:0] CHAR_C    = 8'h63;

  localparam logic [1:0] VERDICT_UPGRADE   = 2'd0;
  localparam logic [1:0] VERDICT_INVALID   = 2'd1;
  localparam logic [1:0] VERDICT_NOT_NEWER = 2'd2;

  localparam logic STR_CURRENT   = 1'b0;
  localparam logic STR_CANDIDATE = 1'b1;

  typedef enum logic [6:0] {
    PH_MAJOR = 7'b0000001,
    PH_MINOR = 7'b0000010,
    PH_PATCH = 7'b0000100,
    PH_DASH  = 7'b0001000,
    PH_R     = 7'b0010000,
    PH_C     = 7'b0100000,
    PH_RC    = 7'b1000000
  } phase_t;

  typedef logic [NUM_W-1:0] num_t;

endpackage

[design/version_string_upgrade_check_top.sv]
// channel | ports                                  | direction
// request | in_valid, in_stall, in_which_string,   | in
//         | in_char_byte                           |
// result  | out_valid, out_stall, out_verdict      | out
//
// one byte is taken every cycle while in_stall is low; the parser state updates once per byte
// a verdict is registered on out_verdict, with out_valid, when its terminating byte leaves the byte stage
// rst_n is synchronous and active low and clears the parser and the stored version
// a stalled verdict holds the byte stage only when that byte is a candidate terminator
module version_string_upgrade_check_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_which_string,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict
);
  import vsuc_pkg::*;

  logic       st_v_r, st_v_nxt;
  logic       st_which_r, st_which_nxt;
  logic [7:0] st_char_r, st_char_nxt;

  phase_t phase_r, phase_nxt;
  logic   started_r, started_nxt;
  logic   lz_r, lz_nxt;
  logic   perr_r, perr_nxt;
  num_t   accum_r, accum_nxt;
  num_t   wmajor_r, wmajor_nxt;
  num_t   wminor_r, wminor_nxt;
  num_t   wpatch_r, wpatch_nxt;
  logic   wrc_r, wrc_nxt;

  num_t   smajor_r, smajor_nxt;
  num_t   sminor_r, sminor_nxt;
  num_t   spatch_r, spatch_nxt;
  num_t   srcnum_r, srcnum_nxt;
  logic   src_r, src_nxt;
  logic   svalid_r, svalid_nxt;

  logic       out_v_r, out_v_nxt;
  logic [1:0] out_verdict_r, out_verdict_nxt;

  logic       is_term;
  logic       cand_term;
  logic       out_free;
  logic       st_go;
  logic       is_digit;
  logic [3:0] digit;
  logic       in_number;
  logic [NUM_W+3:0] acc_wide;
  logic       ovf;
  logic       str_ok;
  num_t       fin_patch;
  num_t       fin_rc;
  logic [1:0] verdict;

  assign is_term   = (st_char_r == CHAR_NUL);
  assign cand_term = is_term && (st_which_r == STR_CANDIDATE);
  assign out_free  = !out_v_r || !out_stall;
  assign st_go     = st_v_r && (!cand_term || out_free);
  assign in_stall  = st_v_r && !st_go;

  assign out_valid   = out_v_r;
  assign out_verdict = out_verdict_r;

  assign is_digit  = (st_char_r >= CHAR_ZERO) && (st_char_r <= CHAR_NINE);
  assign digit     = st_char_r[3:0];
  assign in_number = (phase_r == PH_MAJOR) || (phase_r == PH_MINOR) ||
                     (phase_r == PH_PATCH) || (phase_r == PH_RC);
  assign acc_wide  = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) +
                     {{NUM_W{1'b0}}, digit};
  assign ovf       = |acc_wide[NUM_W+3:NUM_W];

  always_comb begin
    str_ok    = 1'b0;
    fin_patch = wpatch_r;
    fin_rc    = '0;
    if (!perr_r && started_r) begin
      if (phase_r == PH_PATCH) begin
        fin_patch = accum_r;
        str_ok    = 1'b1;
      end else if (phase_r == PH_RC && accum_r != '0) begin
        fin_rc = accum_r;
        str_ok = 1'b1;
      end
    end
  end

  always_comb begin
    if (!str_ok || !svalid_r) begin
      verdict = VERDICT_INVALID;
    end else if (wmajor_r != smajor_r) begin
      verdict = (wmajor_r > smajor_r) ? VERDICT_UPGRADE : VERDICT_NOT_NEWER;
    end else if (wminor_r != sminor_r) begin
      verdict = (wminor_r > sminor_r) ? VERDICT_UPGRADE : VERDICT_NOT_NEWER;
    end else if (fin_patch != spatch_r) begin
      verdict = (fin_patch > spatch_r) ? VERDICT_UPGRADE : VERDICT_NOT_NEWER;
    end else if (wrc_r != src_r) begin
      verdict = wrc_r ? VERDICT_NOT_NEWER : VERDICT_UPGRADE;
    end else if (wrc_r && fin_rc > srcnum_r) begin
      verdict = VERDICT_UPGRADE;
    end else begin
      verdict = VERDICT_NOT_NEWER;
    end
  end

  always_comb begin
    st_v_nxt     = st_v_r;
    st_which_nxt = st_which_r;
    st_char_nxt  = st_char_r;
    if (!in_stall) begin
      st_v_nxt     = in_valid;
      st_which_nxt = in_which_string;
      st_char_nxt  = in_char_byte;
    end

    phase_nxt   = phase_r;
    started_nxt = started_r;
    lz_nxt      = lz_r;
    perr_nxt    = perr_r;
    accum_nxt   = accum_r;
    wmajor_nxt  = wmajor_r;
    wminor_nxt  = wminor_r;
    wpatch_nxt  = wpatch_r;
    wrc_nxt     = wrc_r;
    smajor_nxt  = smajor_r;
    sminor_nxt  = sminor_r;
    spatch_nxt  = spatch_r;
    srcnum_nxt  = srcnum_r;
    src_nxt     = src_r;
    svalid_nxt  = svalid_r;

    out_v_nxt       = out_v_r && out_stall;
    out_verdict_nxt = out_verdict_r;

    if (st_go) begin
      if (!is_term) begin
        if (!perr_r) begin
          priority if (is_digit) begin
            if (!in_number || (started_r && lz_r) || ovf) begin
              perr_nxt = 1'b1;
            end else begin
              accum_nxt = acc_wide[NUM_W-1:0];
              if (!started_r) begin
                started_nxt = 1'b1;
                lz_nxt      = (digit == 4'd0);
              end
            end
          end else if (st_char_r == CHAR_DOT && started_r && phase_r == PH_MAJOR) begin
            wmajor_nxt  = accum_r;
            started_nxt = 1'b0;
            lz_nxt      = 1'b0;
            accum_nxt   = '0;
            phase_nxt   = PH_MINOR;
          end else if (st_char_r == CHAR_DOT && started_r && phase_r == PH_MINOR) begin
            wminor_nxt  = accum_r;
            started_nxt = 1'b0;
            lz_nxt      = 1'b0;
            accum_nxt   = '0;
            phase_nxt   = PH_PATCH;
          end else if (st_char_r == CHAR_DASH && started_r && phase_r == PH_PATCH) begin
            wpatch_nxt  = accum_r;
            wrc_nxt     = 1'b1;
            started_nxt = 1'b0;
            lz_nxt      = 1'b0;
            accum_nxt   = '0;
            phase_nxt   = PH_DASH;
          end else if (st_char_r == CHAR_R && phase_r == PH_DASH) begin
            phase_nxt = PH_R;
          end else if (st_char_r == CHAR_C && phase_r == PH_R) begin
            phase_nxt = PH_C;
          end else if (st_char_r == CHAR_DOT && phase_r == PH_C) begin
            phase_nxt = PH_RC;
          end else begin
            perr_nxt = 1'b1;
          end
        end
      end else begin
        if (st_which_r == STR_CURRENT) begin
          svalid_nxt = str_ok;
          if (str_ok) begin
            smajor_nxt = wmajor_r;
            sminor_nxt = wminor_r;
            spatch_nxt = fin_patch;
            src_nxt    = wrc_r;
            srcnum_nxt = fin_rc;
          end
        end else begin
          out_v_nxt       = 1'b1;
          out_verdict_nxt = verdict;
        end
        phase_nxt   = PH_MAJOR;
        started_nxt = 1'b0;
        lz_nxt      = 1'b0;
        perr_nxt    = 1'b0;
        accum_nxt   = '0;
        wmajor_nxt  = '0;
        wminor_nxt  = '0;
        wpatch_nxt  = '0;
        wrc_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_which_r    <= st_which_nxt;
    st_char_r     <= st_char_nxt;
    out_verdict_r <= out_verdict_nxt;
    if (!rst_n) begin
      st_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= PH_MAJOR;
      started_r <= 1'b0;
      lz_r     <= 1'b0;
      perr_r   <= 1'b0;
      accum_r  <= '0;
      wmajor_r <= '0;
      wminor_r <= '0;
      wpatch_r <= '0;
      wrc_r    <= 1'b0;
      smajor_r <= '0;
      sminor_r <= '0;
      spatch_r <= '0;
      srcnum_r <= '0;
      src_r    <= 1'b0;
      svalid_r <= 1'b0;
    end else begin
      st_v_r   <= st_v_nxt;
      out_v_r  <= out_v_nxt;
      phase_r  <= phase_nxt;
      started_r <= started_nxt;
      lz_r     <= lz_nxt;
      perr_r   <= perr_nxt;
      accum_r  <= accum_nxt;
      wmajor_r <= wmajor_nxt;
      wminor_r <= wminor_nxt;
      wpatch_r <= wpatch_nxt;
      wrc_r    <= wrc_nxt;
      smajor_r <= smajor_nxt;
      sminor_r <= sminor_nxt;
      spatch_r <= spatch_nxt;
      srcnum_r <= srcnum_nxt;
      src_r    <= src_nxt;
      svalid_r <= svalid_nxt;
    end
  end

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (st_v_r && cand_term && out_v_r && out_stall))
    else $error("request stalled without a blocked verdict");

  a_cand_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_go && cand_term) |=> (out_v_r && out_verdict_r == $past(verdict)))
    else $error("candidate terminator did not load a verdict");

  a_term_clears_parser: assert property (@(posedge clk) disable iff (!rst_n)
    (st_go && is_term) |=> (phase_r == PH_MAJOR && !perr_r && !started_r
                            && accum_r == '0))
    else $error("parser not cleared after terminator");

  a_lz_needs_number: assert property (@(posedge clk) disable iff (!rst_n)
    lz_r |-> (started_r && accum_r == '0))
    else $error("leading zero flag without a zero number");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_verdict_r == VERDICT_UPGRADE || out_verdict_r == VERDICT_INVALID
                 || out_verdict_r == VERDICT_NOT_NEWER))
    else $error("verdict code out of range");

endmodule
